// ----- rtl/brvp_pkg.sv -----
// shared constants and types for the block residency victim picker
package brvp_pkg;

  localparam int NB      = 64;
  localparam int IDX_W   = 6;
  localparam int CNT_W   = 7;
  localparam int SIZE_W  = 32;
  localparam int SUM_W   = 40;
  localparam int STAMP_W = 48;

  localparam logic [2:0] CMD_REG    = 3'd0;
  localparam logic [2:0] CMD_RES    = 3'd1;
  localparam logic [2:0] CMD_EVICT  = 3'd2;
  localparam logic [2:0] CMD_TOUCH  = 3'd3;
  localparam logic [2:0] CMD_PIN    = 3'd4;
  localparam logic [2:0] CMD_PICK   = 3'd5;
  localparam logic [2:0] CMD_BUDGET = 3'd6;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RANGE    = 2'd1;
  localparam logic [1:0] ST_ZERO     = 2'd2;
  localparam logic [1:0] ST_RESIDENT = 2'd3;

  localparam logic REG_BLOCKS = 1'b0;
  localparam logic REG_MODE   = 1'b1;

  typedef struct packed {
    logic             size_we;
    logic             stamp_we;
    logic             stamp_clr;
    logic [IDX_W-1:0] wr_idx;
    logic [IDX_W-1:0] size_rd_idx;
    logic [IDX_W-1:0] stamp_rd_idx;
  } tbl_req_t;

  typedef struct packed {
    logic             clear;
    logic             en;
    logic             cand;
    logic             mru;
    logic [IDX_W-1:0] idx;
  } cmp_req_t;

  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] idx;
  } cmp_res_t;

endpackage

// ----- rtl/brvp_table.sv -----
// size and stamp memories with per-entry written marks and registered reads
module brvp_table import brvp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  tbl_req_t           req,
  input  logic [SIZE_W-1:0]  size_wdata,
  input  logic [STAMP_W-1:0] stamp_wdata,
  output logic [SIZE_W-1:0]  size_q,
  output logic [STAMP_W-1:0] stamp_q
);

  logic [SIZE_W-1:0]  size_mem  [NB];
  logic [STAMP_W-1:0] stamp_mem [NB];
  logic [NB-1:0]      size_vld_r;
  logic [NB-1:0]      stamp_vld_r;
  logic [SIZE_W-1:0]  size_rd_r;
  logic [STAMP_W-1:0] stamp_rd_r;
  logic               size_ok_r;
  logic               stamp_ok_r;

  always_ff @(posedge clk) begin
    if (req.size_we) begin
      size_mem[req.wr_idx] <= size_wdata;
    end
    if (req.stamp_we) begin
      stamp_mem[req.wr_idx] <= stamp_wdata;
    end
    size_rd_r  <= size_mem[req.size_rd_idx];
    stamp_rd_r <= stamp_mem[req.stamp_rd_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_vld_r  <= '0;
      stamp_vld_r <= '0;
      size_ok_r   <= 1'b0;
      stamp_ok_r  <= 1'b0;
    end else begin
      if (req.size_we) begin
        size_vld_r[req.wr_idx] <= 1'b1;
      end
      if (req.stamp_we) begin
        stamp_vld_r[req.wr_idx] <= 1'b1;
      end else if (req.stamp_clr) begin
        stamp_vld_r[req.wr_idx] <= 1'b0;
      end
      size_ok_r  <= size_vld_r[req.size_rd_idx];
      stamp_ok_r <= stamp_vld_r[req.stamp_rd_idx];
    end
  end

  assign size_q  = size_ok_r ? size_rd_r : '0;
  assign stamp_q = stamp_ok_r ? stamp_rd_r : '0;

endmodule

// ----- rtl/brvp_cmp.sv -----
// shared stamp comparator holding the best candidate of a scan
module brvp_cmp import brvp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cmp_req_t           req,
  input  logic [STAMP_W-1:0] stamp,
  output cmp_res_t           res
);

  logic               best_vld_r;
  logic [IDX_W-1:0]   best_idx_r;
  logic [STAMP_W-1:0] best_stamp_r;
  logic               better;

  // strict compare keeps the lower index on ties
  assign better = req.mru ? (stamp > best_stamp_r) : (stamp < best_stamp_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_vld_r <= 1'b0;
    end else if (req.clear) begin
      best_vld_r <= 1'b0;
    end else if (req.en && req.cand && (!best_vld_r || better)) begin
      best_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!req.clear && req.en && req.cand && (!best_vld_r || better)) begin
      best_idx_r   <= req.idx;
      best_stamp_r <= stamp;
    end
  end

  assign res.vld = best_vld_r;
  assign res.idx = best_idx_r;

endmodule

// ----- rtl/block_residency_victim_picker.sv -----
// top level: residency table, command sequencer and victim scan
// flow: touch, pin, range error and unused code go straight to emit; register, resident, evict pass an execute state
// pick one: the scan walks every entry in use (at least one), then settles, resolves and emits
// evict to budget: one scan per victim, then the victim size is read and taken off the simulated total
// throughput: one command at a time, as in_ready is high only while the sequencer is idle
// reset (rst_n, synchronous): table reads as all zero, totals and counter cleared at once
module block_residency_victim_picker import brvp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // command words
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_cmd,
  input  logic [IDX_W-1:0]   in_block_index,
  input  logic [SIZE_W-1:0]  in_block_bytes,
  input  logic               in_pin_value,
  input  logic signed [6:0]  in_excluded_index,
  input  logic [SUM_W-1:0]   in_budget_bytes,
  // result words
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic               out_victim_valid,
  output logic [IDX_W-1:0]   out_victim_index,
  output logic               out_last_of_run,
  output logic [CNT_W-1:0]   out_victims_chosen,
  output logic [CNT_W-1:0]   out_resident_total,
  output logic [SUM_W-1:0]   out_resident_byte_sum,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_SCAN, S_SDONE, S_RESOLVE, S_VRD, S_VSZ, S_EMIT
  } state_t;

  state_t state_r;

  // configuration
  logic [CNT_W-1:0] blocks_r;
  logic             mru_r;
  logic [CNT_W-1:0] live;

  // per-entry flags
  logic [NB-1:0] resident_r;
  logic [NB-1:0] pinned_r;
  logic [NB-1:0] hidden_r;

  // totals and access counter
  logic [CNT_W-1:0]   res_cnt_r;
  logic [SUM_W-1:0]   res_sum_r;
  logic [STAMP_W-1:0] acc_r;

  // latched command
  logic [2:0]        cmd_r;
  logic [IDX_W-1:0]  idx_r;
  logic [SIZE_W-1:0] bytes_r;
  logic [6:0]        excl_r;
  logic [SUM_W-1:0]  budget_r;

  // scan and victim list
  logic [IDX_W-1:0] ptr_r;
  logic             issue_r;
  logic             cand_r;
  logic [IDX_W-1:0] cidx_r;
  logic             pend_vld_r;
  logic [IDX_W-1:0] pend_idx_r;
  logic [CNT_W-1:0] k_r;
  logic [SUM_W-1:0] sim_r;
  logic [SUM_W-1:0] sim_nxt;

  // staged result word
  logic [1:0]       em_st_r;
  logic             em_vv_r;
  logic [IDX_W-1:0] em_vi_r;
  logic             em_last_r;
  logic [CNT_W-1:0] em_k_r;
  state_t           ret_r;

  // output register
  logic             out_valid_r;
  logic [1:0]       out_st_r;
  logic             out_vv_r;
  logic [IDX_W-1:0] out_vi_r;
  logic             out_last_r;
  logic [CNT_W-1:0] out_k_r;
  logic [CNT_W-1:0] out_cnt_r;
  logic [SUM_W-1:0] out_sum_r;

  tbl_req_t           treq;
  cmp_req_t           creq;
  cmp_res_t           cres;
  logic [SIZE_W-1:0]  size_q;
  logic [STAMP_W-1:0] stamp_q;

  logic in_acc;
  logic in_idx_ok;
  logic slot_free;
  logic scan_last;
  logic ptr_cand;

  assign live      = (blocks_r > CNT_W'(NB)) ? CNT_W'(NB) : blocks_r;
  assign in_idx_ok = {1'b0, in_block_index} < live;
  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign scan_last = (live == '0) || ({1'b0, ptr_r} == live - CNT_W'(1));

  // a candidate is in range, resident, unpinned, not already listed and not the excluded entry
  assign ptr_cand = ({1'b0, ptr_r} < live) && resident_r[ptr_r] && !pinned_r[ptr_r]
                    && !hidden_r[ptr_r] && (excl_r[6] || (excl_r[5:0] != ptr_r));

  // victim size taken off the simulated total, floored at zero
  assign sim_nxt = (sim_r > SUM_W'(size_q)) ? (sim_r - SUM_W'(size_q)) : '0;

  // table access
  always_comb begin
    treq.size_we      = (state_r == S_EXEC) && (cmd_r == CMD_REG) && (bytes_r != '0);
    treq.stamp_clr    = treq.size_we;
    treq.stamp_we     = in_acc && (in_cmd == CMD_TOUCH) && in_idx_ok;
    treq.wr_idx       = (state_r == S_IDLE) ? in_block_index : idx_r;
    treq.size_rd_idx  = (state_r == S_IDLE) ? in_block_index : pend_idx_r;
    treq.stamp_rd_idx = ptr_r;
  end

  brvp_table u_table (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (treq),
    .size_wdata  (bytes_r),
    .stamp_wdata (acc_r + STAMP_W'(1)),
    .size_q      (size_q),
    .stamp_q     (stamp_q)
  );

  // comparator sees the stamp in the cycle after its address went out
  always_comb begin
    creq.clear = in_acc || ((state_r == S_VSZ) && !(sim_nxt <= budget_r || k_r == CNT_W'(NB)));
    creq.en    = issue_r;
    creq.cand  = cand_r;
    creq.mru   = mru_r;
    creq.idx   = cidx_r;
  end

  brvp_cmp u_cmp (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (creq),
    .stamp (stamp_q),
    .res   (cres)
  );

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MODE) ? {31'b0, mru_r} : {25'b0, blocks_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blocks_r <= '0;
      mru_r    <= 1'b0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_BLOCKS) begin
        blocks_r <= pwdata[CNT_W-1:0];
      end else begin
        mru_r <= pwdata[0];
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      resident_r  <= '0;
      pinned_r    <= '0;
      hidden_r    <= '0;
      res_cnt_r   <= '0;
      res_sum_r   <= '0;
      acc_r       <= '0;
      issue_r     <= 1'b0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // one comparator slot follows each scan cycle
      issue_r <= (state_r == S_SCAN);
      // while emitting, the held word is either taken and replaced or kept
      if (out_valid_r && out_ready && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            cmd_r      <= in_cmd;
            idx_r      <= in_block_index;
            bytes_r    <= in_block_bytes;
            excl_r     <= in_excluded_index;
            budget_r   <= in_budget_bytes;
            hidden_r   <= '0;
            ptr_r      <= '0;
            k_r        <= '0;
            pend_vld_r <= 1'b0;
            sim_r      <= res_sum_r;
            em_st_r    <= (in_cmd <= CMD_PIN && !in_idx_ok) ? ST_RANGE : ST_OK;
            em_vv_r    <= 1'b0;
            em_vi_r    <= '0;
            em_last_r  <= 1'b1;
            em_k_r     <= '0;
            ret_r      <= S_IDLE;
            if (in_cmd <= CMD_PIN && !in_idx_ok) begin
              state_r <= S_EMIT;
            end else if (in_cmd == CMD_REG || in_cmd == CMD_RES || in_cmd == CMD_EVICT) begin
              state_r <= S_EXEC;
            end else if (in_cmd == CMD_TOUCH) begin
              acc_r   <= acc_r + STAMP_W'(1);
              state_r <= S_EMIT;
            end else if (in_cmd == CMD_PIN) begin
              pinned_r[in_block_index] <= in_pin_value;
              state_r <= S_EMIT;
            end else if (in_cmd == CMD_PICK) begin
              state_r <= S_SCAN;
            end else if (in_cmd == CMD_BUDGET && res_sum_r > in_budget_bytes) begin
              state_r <= S_SCAN;
            end else begin
              state_r <= S_EMIT;
            end
          end
        end
        S_EXEC: begin
          state_r <= S_EMIT;
          case (cmd_r)
            CMD_REG: begin
              if (bytes_r == '0) begin
                em_st_r <= ST_ZERO;
              end else if (resident_r[idx_r]) begin
                // re-registering a resident entry takes it out of the totals
                resident_r[idx_r] <= 1'b0;
                res_cnt_r <= res_cnt_r - CNT_W'(1);
                res_sum_r <= res_sum_r - SUM_W'(size_q);
              end
            end
            CMD_RES: begin
              if (resident_r[idx_r]) begin
                em_st_r <= ST_RESIDENT;
              end else begin
                resident_r[idx_r] <= 1'b1;
                res_cnt_r <= res_cnt_r + CNT_W'(1);
                res_sum_r <= res_sum_r + SUM_W'(size_q);
              end
            end
            default: begin
              if (resident_r[idx_r]) begin
                resident_r[idx_r] <= 1'b0;
                res_cnt_r <= res_cnt_r - CNT_W'(1);
                res_sum_r <= res_sum_r - SUM_W'(size_q);
              end
            end
          endcase
        end
        S_SCAN: begin
          cand_r  <= ptr_cand;
          cidx_r  <= ptr_r;
          ptr_r   <= ptr_r + IDX_W'(1);
          if (scan_last) begin
            state_r <= S_SDONE;
          end
        end
        S_SDONE: begin
          state_r <= S_RESOLVE;
        end
        S_RESOLVE: begin
          if (cmd_r == CMD_PICK) begin
            em_vv_r   <= cres.vld;
            em_vi_r   <= cres.vld ? cres.idx : '0;
            em_k_r    <= cres.vld ? CNT_W'(1) : '0;
            em_last_r <= 1'b1;
            ret_r     <= S_IDLE;
            state_r   <= S_EMIT;
          end else if (!cres.vld) begin
            // no candidate left: the held victim, if any, closes the run
            em_vv_r    <= pend_vld_r;
            em_vi_r    <= pend_vld_r ? pend_idx_r : '0;
            em_k_r     <= k_r;
            em_last_r  <= 1'b1;
            ret_r      <= S_IDLE;
            pend_vld_r <= 1'b0;
            state_r    <= S_EMIT;
          end else begin
            hidden_r[cres.idx] <= 1'b1;
            pend_vld_r <= 1'b1;
            pend_idx_r <= cres.idx;
            k_r        <= k_r + CNT_W'(1);
            if (pend_vld_r) begin
              // a further victim exists, so the held one is not last
              em_vv_r   <= 1'b1;
              em_vi_r   <= pend_idx_r;
              em_k_r    <= k_r;
              em_last_r <= 1'b0;
              ret_r     <= S_VRD;
              state_r   <= S_EMIT;
            end else begin
              state_r <= S_VRD;
            end
          end
        end
        S_VRD: begin
          state_r <= S_VSZ;
        end
        S_VSZ: begin
          sim_r <= sim_nxt;
          ptr_r <= '0;
          if (sim_nxt <= budget_r || k_r == CNT_W'(NB)) begin
            em_vv_r    <= 1'b1;
            em_vi_r    <= pend_idx_r;
            em_k_r     <= k_r;
            em_last_r  <= 1'b1;
            ret_r      <= S_IDLE;
            pend_vld_r <= 1'b0;
            state_r    <= S_EMIT;
          end else begin
            state_r <= S_SCAN;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_st_r    <= em_st_r;
            out_vv_r    <= em_vv_r;
            out_vi_r    <= em_vi_r;
            out_last_r  <= em_last_r;
            out_k_r     <= em_k_r;
            out_cnt_r   <= res_cnt_r;
            out_sum_r   <= res_sum_r;
            state_r     <= ret_r;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid             = out_valid_r;
  assign out_status            = out_st_r;
  assign out_victim_valid      = out_vv_r;
  assign out_victim_index      = out_vi_r;
  assign out_last_of_run       = out_last_r;
  assign out_victims_chosen    = out_k_r;
  assign out_resident_total    = out_cnt_r;
  assign out_resident_byte_sum = out_sum_r;

  // busy after taking a command word
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("ready while a command is in progress");

  // a named victim is always counted
  a_victim_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_victim_valid) |-> (out_victims_chosen != '0))
    else $error("victim word with zero count");

  // a held victim only exists while evicting to budget
  a_pend_budget: assert property (@(posedge clk) disable iff (!rst_n)
    pend_vld_r |-> (cmd_r == CMD_BUDGET && state_r != S_IDLE))
    else $error("held victim outside evict to budget");

endmodule
